FILE: rtl/core/ray_unit_sphere_intersect_core_assert.svh
`ifndef RAY_UNIT_SPHERE_INTERSECT_CORE_ASSERT_SVH
`define RAY_UNIT_SPHERE_INTERSECT_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define RUSI_CHK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ray sphere core check failed");

// Next-cycle implication, checked while out of reset.
`define RUSI_CHK_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ray sphere core check failed");

`endif

FILE: rtl/core/rusi_pkg.sv
package rusi_pkg;

    // Fixed-point format of every coordinate and distance.
    localparam int FRAC_BITS = 16;

    // Depth of the queue between front and back end.
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int CRED_W = $clog2(QDEPTH + 2);

    // Root numerator magnitude and divider dividend widths.
    localparam int MAG_W = 65;
    localparam int DVW = MAG_W + FRAC_BITS;

    // Square root of a 128-bit discriminant takes one result bit per step.
    localparam int SQRT_STEPS = 64;
    localparam int CNT_W = $clog2(DVW + 1);

    // The constant one at the scale of a squared coordinate.
    localparam logic [63:0] ONE2 = 64'd1 << (2 * FRAC_BITS);

    // One classified ray handed from front end to back end.
    typedef struct packed {
        logic               miss;
        logic               hpos;
        logic [63:0]        hmag;
        logic [63:0]        a;
        logic [127:0]       disc;
        logic signed [31:0] tmin;
        logic signed [31:0] tmax;
    } t_job;

endpackage

FILE: rtl/core/rusi_front.sv
module rusi_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic signed [31:0]  i_origin_x,
    input  logic signed [31:0]  i_origin_y,
    input  logic signed [31:0]  i_origin_z,
    input  logic signed [31:0]  i_dir_x,
    input  logic signed [31:0]  i_dir_y,
    input  logic signed [31:0]  i_dir_z,
    input  logic signed [31:0]  i_t_near_limit,
    input  logic signed [31:0]  i_t_far_limit,
    output logic                o_valid,
    output rusi_pkg::t_job      o_job
);

    logic [5:0] r_v;

    logic signed [63:0] r_dd0, r_dd1, r_dd2;
    logic signed [63:0] r_oo0, r_oo1, r_oo2;
    logic signed [63:0] r_do0, r_do1, r_do2;
    logic signed [31:0] r_tmin1, r_tmax1;

    logic [63:0]        r_a2, r_oo2s;
    logic signed [65:0] r_h2s;
    logic signed [31:0] r_tmin2, r_tmax2;

    logic [63:0]        r_a3, r_hmag3, r_cmag3;
    logic               r_hpos3, r_cneg3;
    logic signed [31:0] r_tmin3, r_tmax3;

    logic [63:0]        r_p00, r_p01, r_p11, r_q00, r_q01, r_q10, r_q11;
    logic [63:0]        r_a4, r_hmag4;
    logic               r_hpos4, r_cneg4;
    logic signed [31:0] r_tmin4, r_tmax4;

    logic [127:0]       r_hh5, r_ac5;
    logic [63:0]        r_a5, r_hmag5;
    logic               r_hpos5, r_cneg5;
    logic signed [31:0] r_tmin5, r_tmax5;

    rusi_pkg::t_job     r_job;

    logic signed [65:0] h_abs;
    logic               h_ge;

    assign h_abs = r_h2s[65] ? -r_h2s : r_h2s;
    assign h_ge  = r_hh5 >= r_ac5;

    // Valid bits of the six stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_push};
        end
    end

    // Stage 1: the nine coordinate products.
    always_ff @(posedge i_clk) begin
        r_dd0   <= i_dir_x * i_dir_x;
        r_dd1   <= i_dir_y * i_dir_y;
        r_dd2   <= i_dir_z * i_dir_z;
        r_oo0   <= i_origin_x * i_origin_x;
        r_oo1   <= i_origin_y * i_origin_y;
        r_oo2   <= i_origin_z * i_origin_z;
        r_do0   <= i_dir_x * i_origin_x;
        r_do1   <= i_dir_y * i_origin_y;
        r_do2   <= i_dir_z * i_origin_z;
        r_tmin1 <= i_t_near_limit;
        r_tmax1 <= i_t_far_limit;
    end

    // Stage 2: dot products a = D.D, O.O and h = D.O.
    always_ff @(posedge i_clk) begin
        r_a2    <= $unsigned(r_dd0) + $unsigned(r_dd1) + $unsigned(r_dd2);
        r_oo2s  <= $unsigned(r_oo0) + $unsigned(r_oo1) + $unsigned(r_oo2);
        r_h2s   <= 66'(r_do0) + 66'(r_do1) + 66'(r_do2);
        r_tmin2 <= r_tmin1;
        r_tmax2 <= r_tmax1;
    end

    // Stage 3: sign and magnitude of h and of c = O.O - 1.
    always_ff @(posedge i_clk) begin
        r_a3    <= r_a2;
        r_hmag3 <= h_abs[63:0];
        r_hpos3 <= !r_h2s[65] && (r_h2s != '0);
        r_cneg3 <= r_oo2s < rusi_pkg::ONE2;
        r_cmag3 <= (r_oo2s < rusi_pkg::ONE2) ? (rusi_pkg::ONE2 - r_oo2s)
                                              : (r_oo2s - rusi_pkg::ONE2);
        r_tmin3 <= r_tmin2;
        r_tmax3 <= r_tmax2;
    end

    // Stage 4: 32-bit partial products of h*h and a*c.
    always_ff @(posedge i_clk) begin
        r_p00   <= r_hmag3[31:0] * r_hmag3[31:0];
        r_p01   <= r_hmag3[31:0] * r_hmag3[63:32];
        r_p11   <= r_hmag3[63:32] * r_hmag3[63:32];
        r_q00   <= r_a3[31:0] * r_cmag3[31:0];
        r_q01   <= r_a3[31:0] * r_cmag3[63:32];
        r_q10   <= r_a3[63:32] * r_cmag3[31:0];
        r_q11   <= r_a3[63:32] * r_cmag3[63:32];
        r_a4    <= r_a3;
        r_hmag4 <= r_hmag3;
        r_hpos4 <= r_hpos3;
        r_cneg4 <= r_cneg3;
        r_tmin4 <= r_tmin3;
        r_tmax4 <= r_tmax3;
    end

    // Stage 5: assemble the 128-bit products.
    always_ff @(posedge i_clk) begin
        r_hh5   <= {r_p11, r_p00} + ({32'd0, r_p01, 32'd0} << 1);
        r_ac5   <= {r_q11, r_q00} + {32'd0, r_q01, 32'd0} + {32'd0, r_q10, 32'd0};
        r_a5    <= r_a4;
        r_hmag5 <= r_hmag4;
        r_hpos5 <= r_hpos4;
        r_cneg5 <= r_cneg4;
        r_tmin5 <= r_tmin4;
        r_tmax5 <= r_tmax4;
    end

    // Stage 6: discriminant and early miss classification.
    always_ff @(posedge i_clk) begin
        r_job.miss <= (r_a5 == '0) || (!r_cneg5 && !h_ge);
        r_job.disc <= r_cneg5 ? (r_hh5 + r_ac5) : (r_hh5 - r_ac5);
        r_job.hpos <= r_hpos5;
        r_job.hmag <= r_hmag5;
        r_job.a    <= r_a5;
        r_job.tmin <= r_tmin5;
        r_job.tmax <= r_tmax5;
    end

    assign o_valid = r_v[5];
    assign o_job   = r_job;

endmodule

FILE: rtl/core/rusi_queue.sv
module rusi_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rusi_pkg::t_job i_data,
    input  logic           i_pop,
    output rusi_pkg::t_job o_data,
    output logic           o_empty
);

    rusi_pkg::t_job                r_mem [rusi_pkg::QDEPTH];
    logic [rusi_pkg::QPTR_W-1:0]   r_wp, r_rp;
    logic [rusi_pkg::CRED_W-1:0]   r_cnt;

    // Pointers and fill count; the top level keeps pushes within the depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);

endmodule

FILE: rtl/core/rusi_back.sv
module rusi_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rusi_pkg::t_job      i_job,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    output logic                o_hit,
    output logic signed [31:0]  o_t_result
);

    localparam int DVW = rusi_pkg::DVW;
    localparam int FB  = rusi_pkg::FRAC_BITS;

    typedef enum logic [2:0] {ST_IDLE, ST_SQRT, ST_PREP, ST_DIV, ST_DONE} t_state;

    t_state                      r_state;
    rusi_pkg::t_job              r_job;
    logic [127:0]                r_d;
    logic [66:0]                 r_rem;
    logic [63:0]                 r_root;
    logic [DVW-1:0]              r_n0, r_n1;
    logic [63:0]                 r_rm0, r_rm1;
    logic                        r_s0, r_s1;
    logic [rusi_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_valid, r_hit;
    logic signed [31:0]          r_t;

    logic [66:0]         sq_sh, sq_tr, sq_sub;
    logic                sq_ge;
    logic [64:0]         hm65, rt65, m_sum, m_dlt;
    logic                h_ge_r;
    logic [64:0]         a65, dv_sh0, dv_sh1, dv_sub0, dv_sub1;
    logic                dv_ge0, dv_ge1;
    logic signed [31:0]  t0, t1, res;
    logic                hit_c;

    // Saturate a floored quotient of the given sign to 32 bits.
    function automatic logic signed [31:0] f_sat(input logic neg,
                                                 input logic [DVW-1:0] q,
                                                 input logic rem_nz);
        logic [DVW:0] qp;
        logic [31:0]  nv;
        qp = {1'b0, q} + {{DVW{1'b0}}, rem_nz};
        nv = 32'd0 - qp[31:0];
        if (!neg) begin
            return (|q[DVW-1:31]) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
        end
        if ((|qp[DVW:32]) || (qp[31] && (|qp[30:0]))) begin
            return 32'sh8000_0000;
        end
        return $signed(nv);
    endfunction

    // One bit of the integer square root per cycle.
    assign sq_sh  = {r_rem[64:0], r_d[127:126]};
    assign sq_tr  = {1'b0, r_root, 2'b01};
    assign sq_ge  = sq_sh >= sq_tr;
    assign sq_sub = sq_sh - sq_tr;

    // Numerators -h - r and -h + r in sign and magnitude.
    assign hm65   = {1'b0, r_job.hmag};
    assign rt65   = {1'b0, r_root};
    assign m_sum  = hm65 + rt65;
    assign h_ge_r = r_job.hmag >= r_root;
    assign m_dlt  = h_ge_r ? (hm65 - rt65) : (rt65 - hm65);

    // Two restoring dividers by a, one quotient bit each per cycle.
    assign a65     = {1'b0, r_job.a};
    assign dv_sh0  = {r_rm0, r_n0[DVW-1]};
    assign dv_sh1  = {r_rm1, r_n1[DVW-1]};
    assign dv_ge0  = dv_sh0 >= a65;
    assign dv_ge1  = dv_sh1 >= a65;
    assign dv_sub0 = dv_sh0 - a65;
    assign dv_sub1 = dv_sh1 - a65;

    // Root selection against the ray interval.
    assign t0    = f_sat(r_s0, r_n0, |r_rm0);
    assign t1    = f_sat(r_s1, r_n1, |r_rm1);
    assign hit_c = !r_job.miss && !((t0 >= r_job.tmax) || (t1 <= r_job.tmin));
    assign res   = hit_c ? ((t0 > r_job.tmin) ? t0 : t1) : r_job.tmax;

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    // Sequencer with its datapath registers and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_d     <= i_job.disc;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= i_job.miss ? ST_DONE : ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_rem  <= sq_ge ? sq_sub : sq_sh;
                    r_root <= {r_root[62:0], sq_ge};
                    r_d    <= {r_d[125:0], 2'b00};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == rusi_pkg::CNT_W'(rusi_pkg::SQRT_STEPS - 1)) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    if (r_job.hpos) begin
                        r_s0 <= 1'b1;
                        r_n0 <= {m_sum, {FB{1'b0}}};
                        r_s1 <= h_ge_r;
                        r_n1 <= {m_dlt, {FB{1'b0}}};
                    end else begin
                        r_s0 <= !h_ge_r;
                        r_n0 <= {m_dlt, {FB{1'b0}}};
                        r_s1 <= 1'b0;
                        r_n1 <= {m_sum, {FB{1'b0}}};
                    end
                    r_rm0   <= '0;
                    r_rm1   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rm0 <= dv_ge0 ? dv_sub0[63:0] : dv_sh0[63:0];
                    r_rm1 <= dv_ge1 ? dv_sub1[63:0] : dv_sh1[63:0];
                    r_n0  <= {r_n0[DVW-2:0], dv_ge0};
                    r_n1  <= {r_n1[DVW-2:0], dv_ge1};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == rusi_pkg::CNT_W'(DVW - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_valid <= 1'b1;
                    r_hit   <= hit_c;
                    r_t     <= res;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid    = r_valid;
    assign o_hit      = r_hit;
    assign o_t_result = r_t;

endmodule

FILE: rtl/core/ray_unit_sphere_intersect_core.sv
// Channel   | Direction | Handshake                  | Beat contents
// ----------+-----------+----------------------------+----------------------------------
// ray in    | input     | start high while busy low  | origin, direction, t interval
// result    | output    | o_valid, one cycle, no stall | o_hit, o_t_result
//
// The front end is a six-stage pipeline that takes a ray every cycle while busy
// is low into an eight-entry queue; busy rises once eight rays wait in pipeline
// and queue. The back end solves one ray at a time: it takes the ray from the
// queue, runs 64 square root steps, a setup state, 65 + FRAC_BITS divider steps
// (both roots in parallel) and a result state; an early miss goes from the queue
// straight to the result state. The back end takes no new ray from the queue
// until it is through with the last one.
// Reset is synchronous and active low and empties pipeline, queue and back end.
// Results cannot be held off by the receiver.
module ray_unit_sphere_intersect_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  i_origin_x,
    input  logic signed [31:0]  i_origin_y,
    input  logic signed [31:0]  i_origin_z,
    input  logic signed [31:0]  i_dir_x,
    input  logic signed [31:0]  i_dir_y,
    input  logic signed [31:0]  i_dir_z,
    input  logic signed [31:0]  i_t_near_limit,
    input  logic signed [31:0]  i_t_far_limit,
    output logic                o_valid,
    output logic                o_hit,
    output logic signed [31:0]  o_t_result
);

    logic                         accept, pop, f_valid, q_empty;
    rusi_pkg::t_job               f_job, q_job;
    logic [rusi_pkg::CRED_W-1:0]  r_cred;

    assign busy   = (r_cred == rusi_pkg::CRED_W'(rusi_pkg::QDEPTH));
    assign accept = start && !busy;

    // Rays in the pipeline or queue, so the queue never overflows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= '0;
        end else begin
            unique case ({accept, pop})
                2'b10:   r_cred <= r_cred + 1'b1;
                2'b01:   r_cred <= r_cred - 1'b1;
                default: r_cred <= r_cred;
            endcase
        end
    end

    rusi_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (accept),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_origin_z     (i_origin_z),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_dir_z        (i_dir_z),
        .i_t_near_limit (i_t_near_limit),
        .i_t_far_limit  (i_t_far_limit),
        .o_valid        (f_valid),
        .o_job          (f_job)
    );

    rusi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_job),
        .i_pop   (pop),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    rusi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (q_job),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_hit      (o_hit),
        .o_t_result (o_t_result)
    );

endmodule

FILE: rtl/core/rusi_checker.sv
`include "ray_unit_sphere_intersect_core_assert.svh"

module rusi_props (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    logic [rusi_pkg::CRED_W-1:0] r_out;

    // Rays taken whose result beat has not yet appeared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else begin
            unique case ({start && !busy, o_valid})
                2'b10:   r_out <= r_out + 1'b1;
                2'b01:   r_out <= r_out - 1'b1;
                default: r_out <= r_out;
            endcase
        end
    end

    `RUSI_CHK_IMP(a_quiet_after_reset, $past(!i_rst_n), !o_valid && !busy)
    `RUSI_CHK_NXT(a_result_gap, o_valid, !o_valid)
    `RUSI_CHK_IMP(a_no_orphan_result, o_valid, r_out != '0)
    `RUSI_CHK_IMP(a_bounded_backlog, 1'b1, r_out <= rusi_pkg::CRED_W'(rusi_pkg::QDEPTH + 1))

endmodule

bind ray_unit_sphere_intersect_core rusi_props u_rusi_checker (.*);
